/* design/tcjsa_pkg.sv */
`timescale 1ns / 1ps

package tcjsa_pkg;

    // field widths fixed by the job interface
    localparam int ID_W  = 16;
    localparam int CNT_W = 7;
    localparam int ST_W  = 3;
    localparam int OP_W  = 2;
    localparam int KND_W = 3;

    // result status codes
    localparam logic [ST_W-1:0] ST_ACCEPTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_GRANTED   = 3'd1;
    localparam logic [ST_W-1:0] ST_NONE      = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd4;

    // input operation codes
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH   = 2'd2;

    typedef logic [KND_W-1:0] t_kind;

    // classified command kinds handed from front to back
    localparam t_kind KIND_PUSH_FG = 3'd0;
    localparam t_kind KIND_PUSH_BG = 3'd1;
    localparam t_kind KIND_REQUEST = 3'd2;
    localparam t_kind KIND_FINISH  = 3'd3;
    localparam t_kind KIND_NOP     = 3'd4;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   id;
    } t_cmd;

endpackage

/* design/tcjsa_in_if.sv */
`timescale 1ns / 1ps

interface tcjsa_in_if import tcjsa_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] op;
    logic            priority_req;
    logic [ID_W-1:0] job_id;

    modport source (output valid, output op, output priority_req, output job_id,
                    input ready);
    modport sink   (input valid, input op, input priority_req, input job_id,
                    output ready);
endinterface

/* design/tcjsa_out_if.sv */
`timescale 1ns / 1ps

interface tcjsa_out_if import tcjsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  granted_id;
    logic             was_background;
    logic [CNT_W-1:0] running_background;

    modport source (output valid, output status, output granted_id,
                    output was_background, output running_background,
                    input ready);
    modport sink   (input valid, input status, input granted_id,
                    input was_background, input running_background,
                    output ready);
endinterface

/* design/tcjsa_front.sv */
`timescale 1ns / 1ps

module tcjsa_front import tcjsa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcjsa_in_if.sink     i_job_if,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready,
    output t_cmd         o_cmd
);

    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       r_q [2];
    t_cmd       cls_cmd;
    logic       push;
    logic       pop;

    // classify the incoming beat
    always_comb begin
        cls_cmd.id = i_job_if.job_id;
        unique case (i_job_if.op)
            OP_DISPATCH: cls_cmd.kind = i_job_if.priority_req ? KIND_PUSH_BG : KIND_PUSH_FG;
            OP_REQUEST:  cls_cmd.kind = KIND_REQUEST;
            OP_FINISH:   cls_cmd.kind = KIND_FINISH;
            default:     cls_cmd.kind = KIND_NOP;
        endcase
    end

    // two-entry command queue
    assign i_job_if.ready = (r_cnt != 2'd2);
    assign push           = i_job_if.valid && i_job_if.ready;
    assign o_cmd_valid    = (r_cnt != 2'd0);
    assign pop            = o_cmd_valid && i_cmd_ready;
    assign o_cmd          = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls_cmd;
        end
    end

endmodule

/* design/tcjsa_back.sv */
`timescale 1ns / 1ps

module tcjsa_back import tcjsa_pkg::*; #(
    parameter int STACK_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  t_cmd             i_cmd,
    input  logic [CNT_W-1:0] i_max_bg,
    tcjsa_out_if.source      o_res_if
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STACK_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic              r_state, n_state;
    logic [FILL_W-1:0] r_fore_fill, n_fore_fill;
    logic [FILL_W-1:0] r_back_fill, n_back_fill;
    logic [CNT_W-1:0]  r_running, n_running;
    logic              r_pend_bg, n_pend_bg;

    logic [ID_W-1:0]   r_fore_mem [STACK_DEPTH];
    logic [ID_W-1:0]   r_back_mem [STACK_DEPTH];
    logic [ID_W-1:0]   r_fore_rd;
    logic [ID_W-1:0]   r_back_rd;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    logic [ID_W-1:0]   r_out_gid;
    logic              r_out_wasb;
    logic [CNT_W-1:0]  r_out_running;

    logic              out_free;
    logic              take;
    logic              bg_ok;
    logic              fg_ok;
    logic              wr_fore, wr_back, rd_fore, rd_back;
    logic              ld_out;
    logic [ST_W-1:0]   ld_status;
    logic [ID_W-1:0]   ld_gid;
    logic              ld_wasb;

    assign out_free    = !r_out_valid || o_res_if.ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign take        = o_cmd_ready && i_cmd_valid;
    assign bg_ok       = (r_back_fill != '0) && (r_running < i_max_bg);
    assign fg_ok       = (r_fore_fill != '0);

    // command execution
    always_comb begin
        n_state     = r_state;
        n_fore_fill = r_fore_fill;
        n_back_fill = r_back_fill;
        n_running   = r_running;
        n_pend_bg   = r_pend_bg;
        wr_fore     = 1'b0;
        wr_back     = 1'b0;
        rd_fore     = 1'b0;
        rd_back     = 1'b0;
        ld_out      = 1'b0;
        ld_status   = ST_NONE;
        ld_gid      = '0;
        ld_wasb     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_cmd.kind)
                        KIND_PUSH_FG: begin
                            ld_out = 1'b1;
                            if (r_fore_fill == FILL_FULL) begin
                                ld_status = ST_FULL;
                            end else begin
                                wr_fore     = 1'b1;
                                n_fore_fill = r_fore_fill + FILL_W'(1);
                                ld_status   = ST_ACCEPTED;
                            end
                        end
                        KIND_PUSH_BG: begin
                            ld_out = 1'b1;
                            if (r_back_fill == FILL_FULL) begin
                                ld_status = ST_FULL;
                            end else begin
                                wr_back     = 1'b1;
                                n_back_fill = r_back_fill + FILL_W'(1);
                                ld_status   = ST_ACCEPTED;
                            end
                        end
                        KIND_REQUEST: begin
                            if (bg_ok) begin
                                n_back_fill = r_back_fill - FILL_W'(1);
                                n_running   = r_running + CNT_W'(1);
                                rd_back     = 1'b1;
                                n_pend_bg   = 1'b1;
                                n_state     = S_POP;
                            end else if (fg_ok) begin
                                n_fore_fill = r_fore_fill - FILL_W'(1);
                                rd_fore     = 1'b1;
                                n_pend_bg   = 1'b0;
                                n_state     = S_POP;
                            end else begin
                                ld_out    = 1'b1;
                                ld_status = ST_NONE;
                            end
                        end
                        KIND_FINISH: begin
                            ld_out = 1'b1;
                            if (r_running != '0) begin
                                n_running = r_running - CNT_W'(1);
                                ld_status = ST_ACCEPTED;
                            end else begin
                                ld_status = ST_UNDERFLOW;
                            end
                        end
                        default: begin
                            ld_out    = 1'b1;
                            ld_status = ST_NONE;
                        end
                    endcase
                end
            end
            S_POP: begin
                // stack read data is ready, deliver the grant
                if (out_free) begin
                    ld_out    = 1'b1;
                    ld_status = ST_GRANTED;
                    ld_gid    = r_pend_bg ? r_back_rd : r_fore_rd;
                    ld_wasb   = r_pend_bg;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fore_fill <= '0;
            r_back_fill <= '0;
            r_running   <= '0;
            r_pend_bg   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fore_fill <= n_fore_fill;
            r_back_fill <= n_back_fill;
            r_running   <= n_running;
            r_pend_bg   <= n_pend_bg;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_status  <= ld_status;
            r_out_gid     <= ld_gid;
            r_out_wasb    <= ld_wasb;
            r_out_running <= n_running;
        end
    end

    // foreground stack memory, push at fill, pop reads fill minus one
    always_ff @(posedge i_clk) begin
        if (wr_fore) begin
            r_fore_mem[r_fore_fill[IDX_W-1:0]] <= i_cmd.id;
        end
        if (rd_fore) begin
            r_fore_rd <= r_fore_mem[n_fore_fill[IDX_W-1:0]];
        end
    end

    // background stack memory
    always_ff @(posedge i_clk) begin
        if (wr_back) begin
            r_back_mem[r_back_fill[IDX_W-1:0]] <= i_cmd.id;
        end
        if (rd_back) begin
            r_back_rd <= r_back_mem[n_back_fill[IDX_W-1:0]];
        end
    end

    assign o_res_if.valid              = r_out_valid;
    assign o_res_if.status             = r_out_status;
    assign o_res_if.granted_id         = r_out_gid;
    assign o_res_if.was_background     = r_out_wasb;
    assign o_res_if.running_background = r_out_running;

endmodule

/* design/two_class_job_stack_arbiter_unit.sv */
`timescale 1ns / 1ps

// Two-class job stack arbiter: job ids are pushed onto a foreground or a
// background LIFO of STACK_DEPTH entries each; a request grants the newest
// background job while fewer than max_background of them run, else the newest
// foreground job, and a finish beat lowers the running background count.
// Every input beat yields exactly one result beat. Input beats are classified
// and parked in a two-entry queue; the execution stage takes one command at a
// time. Dispatch, finish and empty requests deliver their result in the cycle
// after leaving the queue, one beat per cycle while the result sink is ready;
// a grant first passes the registered stack read. The stacks need no clearing
// pass: only entries below the fill count are read. max_background
// resets to THREAD_COUNT / 2 and must only be written while the block is idle.

module two_class_job_stack_arbiter_unit import tcjsa_pkg::*; #(
    parameter int STACK_DEPTH  = 32,
    parameter int THREAD_COUNT = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcjsa_in_if.sink         i_job_if,
    tcjsa_out_if.source      o_res_if,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata
);

    localparam logic [CNT_W-1:0] MAX_BG_RST = CNT_W'(THREAD_COUNT / 2);

    logic [CNT_W-1:0] r_max_bg;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;

    // background cap register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bg <= MAX_BG_RST;
        end else if (i_cfg_we) begin
            r_max_bg <= i_cfg_wdata;
        end
    end

    tcjsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_if    (i_job_if),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    tcjsa_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_max_bg    (r_max_bg),
        .o_res_if    (o_res_if)
    );

endmodule

/* design/tcjsa_checker.sv */
`timescale 1ns / 1ps

module tcjsa_checker import tcjsa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_ready,
    input  logic [ST_W-1:0]  i_status,
    input  logic [ID_W-1:0]  i_granted_id,
    input  logic             i_was_background
);

    // no result beat straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    // non-grant beats carry no id and no background flag
    a_nogrant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_GRANTED) |-> (i_granted_id == '0 && !i_was_background))
        else $error("non-grant result carries grant fields");

    // background flag only on grants
    a_bg_is_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_was_background) |-> (i_status == ST_GRANTED))
        else $error("background flag without grant");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_granted_id)))
        else $error("stalled result beat changed");

endmodule

bind two_class_job_stack_arbiter_unit tcjsa_checker u_tcjsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_res_if.valid),
    .i_ready          (o_res_if.ready),
    .i_status         (o_res_if.status),
    .i_granted_id     (o_res_if.granted_id),
    .i_was_background (o_res_if.was_background)
);

/* bench/two_class_job_stack_arbiter_unit_tb.sv */
`timescale 1ns / 1ps

module two_class_job_stack_arbiter_unit_tb;
    import tcjsa_pkg::*;

    localparam int JOB_DEPTH   = 32;
    localparam int THREADS     = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int TAIL_CYCLES = 8;

    // op value with no meaning, the block answers none available
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(THREADS / 2);
    localparam logic [CNT_W-1:0] CAP_ZERO  = '0;
    localparam logic [CNT_W-1:0] CAP_ONE   = 7'd1;
    localparam logic [CNT_W-1:0] CAP_SIXTY_FOUR = 7'd64;
    localparam logic [CNT_W-1:0] CAP_ALL_ONES   = '1;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  granted_id;
        logic             was_background;
        logic [CNT_W-1:0] running;
    } t_job_result;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    tcjsa_in_if  job_if ();
    tcjsa_out_if res_if ();

    two_class_job_stack_arbiter_unit #(
        .STACK_DEPTH  (JOB_DEPTH),
        .THREAD_COUNT (THREADS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_job_if    (job_if),
        .o_res_if    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // scheduler state as the bench sees it
    logic [ID_W-1:0]  fg_jobs [JOB_DEPTH];
    logic [ID_W-1:0]  bg_jobs [JOB_DEPTH];
    int               fg_count;
    int               bg_count;
    logic [CNT_W-1:0] bg_running;
    logic [CNT_W-1:0] bg_cap;

    t_job_result job_results_due [$];
    t_job_result got_head;
    int          mismatches;
    int          idle_pct;
    bit          hold_req;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("two_class_job_stack_arbiter_unit_tb NOT OK");
        $finish;
    end

    // arbitration of one accepted beat, updates the bench state
    function automatic t_job_result arbitrate_job(input logic [OP_W-1:0] op,
                                                  input logic prio,
                                                  input logic [ID_W-1:0] id);
        t_job_result r;
        r.status         = ST_NONE;
        r.granted_id     = '0;
        r.was_background = 1'b0;
        case (op)
            OP_DISPATCH: begin
                if (prio) begin
                    if (bg_count >= JOB_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        bg_jobs[bg_count] = id;
                        bg_count++;
                        r.status = ST_ACCEPTED;
                    end
                end else begin
                    if (fg_count >= JOB_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        fg_jobs[fg_count] = id;
                        fg_count++;
                        r.status = ST_ACCEPTED;
                    end
                end
            end
            OP_REQUEST: begin
                if (bg_count > 0 && bg_running < bg_cap) begin
                    bg_count--;
                    r.granted_id     = bg_jobs[bg_count];
                    r.was_background = 1'b1;
                    r.status         = ST_GRANTED;
                    bg_running++;
                end else if (fg_count > 0) begin
                    fg_count--;
                    r.granted_id = fg_jobs[fg_count];
                    r.status     = ST_GRANTED;
                end
            end
            OP_FINISH: begin
                if (bg_running > 0) begin
                    bg_running--;
                    r.status = ST_ACCEPTED;
                end else begin
                    r.status = ST_UNDERFLOW;
                end
            end
            default: r.status = ST_NONE;
        endcase
        r.running = bg_running;
        return r;
    endfunction

    // send one job beat, returns at the falling edge after acceptance
    task automatic send_job(input logic [OP_W-1:0] op, input logic prio,
                            input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < idle_pct) begin
            job_if.valid <= 1'b0;
            @(negedge clk);
        end
        job_if.valid        <= 1'b1;
        job_if.op           <= op;
        job_if.priority_req <= prio;
        job_if.job_id       <= id;
        @(posedge clk);
        while (!job_if.ready) @(posedge clk);
        job_results_due.push_back(arbitrate_job(op, prio, id));
        @(negedge clk);
    endtask

    // weighted random beat, what is left of 100 goes to the unused op
    task automatic send_random(input int disp_w, input int req_w, input int fin_w);
        int pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < disp_w)
            op = OP_DISPATCH;
        else if (pick < disp_w + req_w)
            op = OP_REQUEST;
        else if (pick < disp_w + req_w + fin_w)
            op = OP_FINISH;
        else
            op = OP_UNUSED;
        send_job(op, 1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // lower valid and wait for every due result
    task automatic drain_jobs();
        job_if.valid <= 1'b0;
        @(negedge clk);
        while (job_results_due.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // cap write, only with the block idle
    task automatic write_cap(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        bg_cap = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // every op and the reset cap, empty stacks and underflow
    task automatic test_basic_ops();
        send_job(OP_DISPATCH, 1'b0, 16'h0000);
        send_job(OP_DISPATCH, 1'b1, 16'hFFFF);
        send_job(OP_REQUEST, 1'b0, 16'h0000);
        send_job(OP_REQUEST, 1'b1, 16'hFFFF);
        send_job(OP_REQUEST, 1'b0, 16'h1234);
        send_job(OP_FINISH, 1'b0, 16'h0000);
        send_job(OP_FINISH, 1'b1, 16'hFFFF);
        send_job(OP_UNUSED, 1'b1, 16'hFFFF);
        send_job(OP_UNUSED, 1'b0, 16'h0000);
        drain_jobs();
    endtask

    // cap at zero and one: background held back while foreground is served
    task automatic test_cap_edges();
        write_cap(CAP_ZERO);
        send_job(OP_DISPATCH, 1'b1, 16'hA5A5);
        send_job(OP_REQUEST, 1'b0, 16'h0000);
        send_job(OP_DISPATCH, 1'b0, 16'h5A5A);
        send_job(OP_REQUEST, 1'b0, 16'h0000);
        send_job(OP_REQUEST, 1'b1, 16'h0000);
        drain_jobs();
        write_cap(CAP_ONE);
        send_job(OP_REQUEST, 1'b0, 16'h0000);
        send_job(OP_DISPATCH, 1'b1, 16'hC3C3);
        send_job(OP_REQUEST, 1'b0, 16'h0000);
        send_job(OP_FINISH, 1'b0, 16'h0000);
        send_job(OP_REQUEST, 1'b0, 16'h0000);
        send_job(OP_FINISH, 1'b1, 16'h0000);
        drain_jobs();
    endtask

    // mixed traffic at the usual cap ceiling
    task automatic test_random_mix();
        write_cap(CAP_SIXTY_FOUR);
        repeat (220) send_random(40, 35, 20);
        drain_jobs();
    endtask

    // long receiver hold-off while dispatches fill both stacks past full
    task automatic test_fill_backpressure();
        write_cap(CAP_ALL_ONES);
        hold_req = 1'b1;
        repeat (100) send_random(85, 10, 4);
        drain_jobs();
    endtask

    // back to back beats with no idling on either side, small caps
    task automatic test_back_to_back();
        write_cap(CNT_W'($urandom_range(0, 8)));
        idle_pct = 0;
        repeat (150) send_random(40, 40, 17);
        drain_jobs();
        idle_pct = 27;
    endtask

    // request heavy traffic that empties the stacks and runs into underflow
    task automatic test_drain_heavy();
        write_cap(CNT_W'($urandom_range(1, 4)));
        repeat (230) send_random(30, 45, 20);
        drain_jobs();
    endtask

    // result sink with random stalls and the long hold-off
    initial begin : res_sink
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [ID_W-1:0] exp_val,
                               input logic [ID_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // compare each result beat with the oldest due result
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (job_results_due.size() == 0) begin
                $error("result beat with nothing due, status %0d", res_if.status);
                mismatches++;
            end else begin
                got_head = job_results_due.pop_front();
                check_field("status", ID_W'(got_head.status), ID_W'(res_if.status));
                check_field("granted_id", got_head.granted_id, res_if.granted_id);
                check_field("was_background", ID_W'(got_head.was_background),
                            ID_W'(res_if.was_background));
                check_field("running_background", ID_W'(got_head.running),
                            ID_W'(res_if.running_background));
            end
        end
    end

    // main sequence
    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        job_if.valid        = 1'b0;
        job_if.op           = OP_DISPATCH;
        job_if.priority_req = 1'b0;
        job_if.job_id       = '0;
        fg_count            = 0;
        bg_count            = 0;
        bg_running          = '0;
        bg_cap              = CAP_RESET;
        mismatches          = 0;
        idle_pct            = 27;
        hold_req            = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basic_ops();
        test_cap_edges();
        test_random_mix();
        test_fill_backpressure();
        test_back_to_back();
        test_drain_heavy();

        if (mismatches == 0 && job_results_due.size() == 0) begin
            $display("two_class_job_stack_arbiter_unit_tb OK");
        end else begin
            $display("two_class_job_stack_arbiter_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
